### rtl/ibcc_pkg.sv
// ----------------------------------------------------------------------------
// ibcc_pkg
// Shared constants, status codes and control types for the interval
// booking conflict check core.
// ----------------------------------------------------------------------------
package ibcc_pkg;

	localparam int CAPACITY = 64;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	localparam int RANGE_W  = 31;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 7;

	localparam logic [STATUS_W-1:0] ST_STORED   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
	localparam logic [STATUS_W-1:0] ST_CONFLICT = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

	typedef struct packed {
		logic load;
		logic issue;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic count_zero;
		logic last_issue;
		logic rd_pending;
	} sts_t;

endpackage

### rtl/ibcc_datapath.sv
// ----------------------------------------------------------------------------
// ibcc_datapath
// Request registers, range table memory, scan address counter, overlap
// compare and result register.
// ----------------------------------------------------------------------------
module ibcc_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [ibcc_pkg::RANGE_W-1:0]   range_start,
	input  logic [ibcc_pkg::RANGE_W-1:0]   range_end,
	input  ibcc_pkg::cmd_t                 cmd,
	output ibcc_pkg::sts_t                 sts,
	output logic                           accepted,
	output logic [ibcc_pkg::STATUS_W-1:0]  status,
	output logic [ibcc_pkg::COUNT_W-1:0]   stored_count
);
	import ibcc_pkg::*;

	logic [2*RANGE_W-1:0] mem [CAPACITY];

	logic [RANGE_W-1:0]  s_q;
	logic [RANGE_W-1:0]  e_q;
	logic [CNT_W-1:0]    count_q;
	logic [ADDR_W-1:0]   idx_q;
	logic                hit_q;
	logic                rd_valid_s1;
	logic [RANGE_W-1:0]  rd_start_s1;
	logic [RANGE_W-1:0]  rd_end_s1;
	logic                accepted_q;
	logic [STATUS_W-1:0] status_q;
	logic [COUNT_W-1:0]  stored_count_q;

	logic                overlap;
	logic                full;
	logic                empty;
	logic [STATUS_W-1:0] status_next;
	logic [CNT_W-1:0]    count_next;

	assign empty   = (s_q == e_q);
	assign full    = (count_q == CNT_W'(CAPACITY));
	assign overlap = (s_q < rd_end_s1) && (e_q > rd_start_s1);

	always_comb begin
		if (empty) begin
			status_next = ST_EMPTY;
		end else if (hit_q) begin
			status_next = ST_CONFLICT;
		end else if (full) begin
			status_next = ST_FULL;
		end else begin
			status_next = ST_STORED;
		end
		count_next = (status_next == ST_STORED) ? count_q + CNT_W'(1) : count_q;
	end

	// table memory: one write at the append slot, one registered read for the scan
	always_ff @(posedge clk) begin
		if (cmd.finish && status_next == ST_STORED) begin
			mem[count_q[ADDR_W-1:0]] <= {s_q, e_q};
		end
		if (cmd.issue) begin
			{rd_start_s1, rd_end_s1} <= mem[idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			idx_q       <= '0;
			hit_q       <= 1'b0;
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= cmd.issue;
			if (cmd.load) begin
				idx_q <= '0;
				hit_q <= 1'b0;
			end else begin
				if (cmd.issue) begin
					idx_q <= idx_q + ADDR_W'(1);
				end
				if (rd_valid_s1 && overlap) begin
					hit_q <= 1'b1;
				end
			end
			if (cmd.finish) begin
				count_q <= count_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			s_q <= range_start;
			e_q <= range_end;
		end
		if (cmd.finish) begin
			accepted_q     <= (status_next == ST_STORED) || (status_next == ST_EMPTY);
			status_q       <= status_next;
			stored_count_q <= COUNT_W'(count_next);
		end
	end

	assign sts.empty      = empty;
	assign sts.count_zero = (count_q == '0);
	assign sts.last_issue = (idx_q == ADDR_W'(count_q - CNT_W'(1)));
	assign sts.rd_pending = rd_valid_s1;

	assign accepted     = accepted_q;
	assign status       = status_q;
	assign stored_count = stored_count_q;

endmodule

### rtl/ibcc_ctrl.sv
// ----------------------------------------------------------------------------
// ibcc_ctrl
// Sequencer for one request: capture, scan of the stored ranges, decision
// and hand-off to the result register.
// ----------------------------------------------------------------------------
module ibcc_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	output logic           out_valid,
	input  logic           out_stall,
	output ibcc_pkg::cmd_t cmd,
	input  ibcc_pkg::sts_t sts
);
	import ibcc_pkg::*;

	typedef enum logic [2:0] {
		IDLE,
		CHECK,
		SCAN,
		DRAIN,
		FINISH
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != IDLE);

	always_comb begin
		cmd        = '0;
		cmd.load   = (state_q == IDLE) && in_valid;
		cmd.issue  = (state_q == SCAN);
		cmd.finish = (state_q == FINISH) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				IDLE: begin
					if (in_valid) begin
						state_q <= CHECK;
					end
				end
				CHECK: begin
					// empty range or empty table needs no scan
					if (sts.empty || sts.count_zero) begin
						state_q <= FINISH;
					end else begin
						state_q <= SCAN;
					end
				end
				SCAN: begin
					if (sts.last_issue) begin
						state_q <= DRAIN;
					end
				end
				DRAIN: begin
					state_q <= FINISH;
				end
				FINISH: begin
					if (out_free) begin
						state_q <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;

	a_finish_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!out_valid_q || !out_stall))
		else $error("result written while previous item still held");

	a_finish_shows_item: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> out_valid_q)
		else $error("finished item not presented");

	a_scan_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == SCAN) |-> (!sts.count_zero && !sts.empty))
		else $error("scan running with nothing to compare");

	a_no_read_at_decision: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == FINISH) |-> !sts.rd_pending)
		else $error("decision taken before last compare landed");

endmodule

### rtl/interval_booking_conflict_check_core.sv
// ----------------------------------------------------------------------------
// interval_booking_conflict_check_core
// Reservation table of half-open ranges with overlap check on each request.
// ----------------------------------------------------------------------------
// Each request [range_start, range_end) is answered by exactly one result
// item. With n ranges stored (n >= 1) a request passes through CHECK, SCAN
// and DRAIN to FINISH; an empty range or an empty table goes from CHECK
// straight to FINISH. SCAN reads the table through its single registered
// read port, one entry per cycle. A result waits in the output register
// while the next request is accepted; only the final step of a request
// waits for that register to drain. Reset empties the table at once (entry
// count cleared, no clearing pass). New requests are taken only in IDLE.
module interval_booking_conflict_check_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [ibcc_pkg::RANGE_W-1:0]  range_start,
	input  logic [ibcc_pkg::RANGE_W-1:0]  range_end,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          accepted,
	output logic [ibcc_pkg::STATUS_W-1:0] status,
	output logic [ibcc_pkg::COUNT_W-1:0]  stored_count
);
	import ibcc_pkg::*;

	cmd_t cmd;
	sts_t sts;

	ibcc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	ibcc_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.range_start  (range_start),
		.range_end    (range_end),
		.cmd          (cmd),
		.sts          (sts),
		.accepted     (accepted),
		.status       (status),
		.stored_count (stored_count)
	);

endmodule
